>>> hdl/eamr_pkg.sv
// shared constants, types and cordic arctangent table for the euler-to-matrix unit
// depends on nothing
`timescale 1ns / 1ps
package eamr_pkg;
   localparam int ANGLE_BITS_DEFAULT    = 16;
   localparam int FRACTION_BITS_DEFAULT = 14;
   localparam int CORDIC_STEPS          = 30;
   localparam int QW                    = 34;   // q30 working width with headroom
   localparam int OUT_W                 = 16;
   localparam logic signed [QW-1:0] Q30_ONE   = 34'sd1073741824;
   localparam logic signed [QW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [QW-1:0] q_type;

   typedef struct packed {
      q_type s;
      q_type c;
   } sincos_type;

   function automatic q_type atan_turn(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
         3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
         6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
         9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
         12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
         15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
         18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
         21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
         24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
         27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
         default: t = 32'd0;
      endcase
      return q_type'({2'b00, t});
   endfunction

   function automatic q_type clamp_one(input q_type v);
      if (v > Q30_ONE) return Q30_ONE;
      if (v < -Q30_ONE) return -Q30_ONE;
      return v;
   endfunction

   // q30 product rounded half up
   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [2*QW-1:0] p;
      p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(64'sd536870912);
      return q_type'(p >>> 30);
   endfunction
endpackage

>>> hdl/eamr_cordic.sv
// pipelined rotation-mode cordic, one register stage per step
// depends on eamr_pkg
`timescale 1ns / 1ps
module eamr_cordic #(
   parameter int ANGLE_BITS = eamr_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ANGLE_BITS-1:0] angle,
   output eamr_pkg::sincos_type  result
);
   import eamr_pkg::*;

   localparam int N = CORDIC_STEPS;

   q_type x_ff [N+1];
   q_type y_ff [N+1];
   q_type z_ff [N+1];
   logic  flip_ff [N+1];
   logic [31:0] turn;
   logic [31:0] turn_rot;
   logic        flip_in;

   // widen or narrow the binary angle to a 32-bit turn fraction
   if (ANGLE_BITS >= 32) begin : g_wide
      assign turn = angle[ANGLE_BITS-1 -: 32];
   end else begin : g_narrow
      assign turn = {angle, {(32-ANGLE_BITS){1'b0}}};
   end

   always_comb begin
      flip_in  = turn[31] ^ turn[30];
      turn_rot = flip_in ? turn + 32'h8000_0000 : turn;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= q_type'($signed(turn_rot));
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (enable) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][QW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_turn(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_turn(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result.c <= clamp_one(flip_ff[N] ? -x_ff[N] : x_ff[N]);
         result.s <= clamp_one(flip_ff[N] ? -y_ff[N] : y_ff[N]);
      end
   end
endmodule

>>> hdl/eamr_matrix.sv
// three-stage product and sum network forming the nine matrix entries
// depends on eamr_pkg
`timescale 1ns / 1ps
module eamr_matrix #(
   parameter int FRACTION_BITS = eamr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 enable,
   input  eamr_pkg::sincos_type yaw,
   input  eamr_pkg::sincos_type pitch,
   input  eamr_pkg::sincos_type roll,
   output logic [9*eamr_pkg::OUT_W-1:0] entries
);
   import eamr_pkg::*;

   localparam int SH = 30 - FRACTION_BITS;

   function automatic logic [OUT_W-1:0] to_out(input q_type v);
      q_type r;
      q_type one;
      one = q_type'(1) <<< FRACTION_BITS;
      r = (SH > 0) ? ((v + (q_type'(1) <<< (SH-1))) >>> SH) : v;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[OUT_W-1:0];
   endfunction

   // stage a: pair products
   q_type cysp_ff, sysp_ff, cycp_ff, sycp_ff, cpsr_ff, cpcr_ff, sycr_ff, cycr_ff, cysr_ff;
   q_type sysr_ff, nsp_ff, sr_a_ff, cr_a_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         cysp_ff <= qmul(yaw.c, pitch.s);
         sysp_ff <= qmul(yaw.s, pitch.s);
         cycp_ff <= qmul(yaw.c, pitch.c);
         sycp_ff <= qmul(yaw.s, pitch.c);
         cpsr_ff <= qmul(pitch.c, roll.s);
         cpcr_ff <= qmul(pitch.c, roll.c);
         sycr_ff <= qmul(yaw.s, roll.c);
         cycr_ff <= qmul(yaw.c, roll.c);
         cysr_ff <= qmul(yaw.c, roll.s);
         sysr_ff <= qmul(roll.s, yaw.s);
         nsp_ff  <= -pitch.s;
         sr_a_ff <= roll.s;
         cr_a_ff <= roll.c;
      end
   end

   // stage b: triple products
   q_type t0_ff, t1_ff, t2_ff, t3_ff;
   q_type cycp_b_ff, sycp_b_ff, nsp_b_ff, cpsr_b_ff, cpcr_b_ff;
   q_type sycr_b_ff, cycr_b_ff, cysr_b_ff, sysr_b_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         t0_ff <= qmul(cysp_ff, sr_a_ff);
         t1_ff <= qmul(sysp_ff, sr_a_ff);
         t2_ff <= qmul(cysp_ff, cr_a_ff);
         t3_ff <= qmul(sysp_ff, cr_a_ff);
         cycp_b_ff <= cycp_ff; sycp_b_ff <= sycp_ff; nsp_b_ff <= nsp_ff;
         cpsr_b_ff <= cpsr_ff; cpcr_b_ff <= cpcr_ff; sycr_b_ff <= sycr_ff;
         cycr_b_ff <= cycr_ff; cysr_b_ff <= cysr_ff; sysr_b_ff <= sysr_ff;
      end
   end

   // stage c: sums and rounding to the output format
   always_ff @(posedge clock) begin
      if (enable) begin
         entries[0*OUT_W +: OUT_W] <= to_out(cycp_b_ff);
         entries[1*OUT_W +: OUT_W] <= to_out(sycp_b_ff);
         entries[2*OUT_W +: OUT_W] <= to_out(nsp_b_ff);
         entries[3*OUT_W +: OUT_W] <= to_out(t0_ff - sycr_b_ff);
         entries[4*OUT_W +: OUT_W] <= to_out(cycr_b_ff + t1_ff);
         entries[5*OUT_W +: OUT_W] <= to_out(cpsr_b_ff);
         entries[6*OUT_W +: OUT_W] <= to_out(sysr_b_ff + t2_ff);
         entries[7*OUT_W +: OUT_W] <= to_out(t3_ff - cysr_b_ff);
         entries[8*OUT_W +: OUT_W] <= to_out(cpcr_b_ff);
      end
   end
endmodule

>>> hdl/euler_angles_to_rotation_matrix_unit.sv
// yaw-pitch-roll angles to 3x3 rotation matrix, top level
// an accepted req beat passes 1 angle register, 30 cordic steps, 1 clamp register
// and 3 matrix stages on its way to its rsp beat;
// throughput one beat per cycle, set by the cordic step pipeline, which advances
// as a whole whenever the output is free
// reset (synchronous, active high) clears the valid bits only; payload is not reset
// depends on eamr_pkg, eamr_cordic, eamr_matrix
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix_unit #(
   parameter int ANGLE_BITS    = eamr_pkg::ANGLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = eamr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // yaw_angle, pitch_angle, roll_angle from bit 0 up
   input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fwd_x/y/z, left_x/y/z, up_x/y/z, 16 bits each from bit 0 up
   output logic [143:0] rsp_tdata
);
   import eamr_pkg::*;

   localparam int LAT = CORDIC_STEPS + 5;   // stages through cordic and matrix

   sincos_type yaw_sc, pitch_sc, roll_sc;
   logic [LAT-1:0] valid_ff, valid_in;
   logic           enable;

   // whole pipeline moves when the last stage is empty or being drained
   assign enable     = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_comb begin
      valid_in = valid_ff;
      if (enable) valid_in = {valid_ff[LAT-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   eamr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
      .clock(clock), .enable(enable),
      .angle(req_tdata[0 +: ANGLE_BITS]), .result(yaw_sc));
   eamr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
      .clock(clock), .enable(enable),
      .angle(req_tdata[ANGLE_BITS +: ANGLE_BITS]), .result(pitch_sc));
   eamr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
      .clock(clock), .enable(enable),
      .angle(req_tdata[2*ANGLE_BITS +: ANGLE_BITS]), .result(roll_sc));

   // cordic covers cordic_steps+2 stages, matrix three more
   eamr_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_matrix (
      .clock(clock), .enable(enable),
      .yaw(yaw_sc), .pitch(pitch_sc), .roll(roll_sc),
      .entries(rsp_tdata));
endmodule

>>> tb/testbench.sv
// self-checking bench for the euler-angles-to-rotation-matrix unit
// drives angle beats, predicts the nine q2.14 entries with a local cordic model
// depends on eamr_pkg and euler_angles_to_rotation_matrix_unit
`timescale 1ns / 1ps
module testbench;
   import eamr_pkg::*;

   localparam int LATENCY   = 35;
   localparam int N_RANDOM  = 930;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] yaw;
   } angles_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // yaw_angle, pitch_angle, roll_angle from bit 0 up
   logic [47:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // fwd_x/y/z, left_x/y/z, up_x/y/z, 16 bits each from bit 0 up
   logic [143:0]  rsp_tdata;

   euler_angles_to_rotation_matrix_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pending matrices in arrival order
   logic [143:0] matrix_queue [$];
   int  errors = 0;
   int  idle_pct = 0;     // sender idle chance, percent
   int  stall_pct = 0;    // receiver stall chance, percent
   bit  hold_off = 0;     // long receiver hold-off in progress
   longint cycles = 0;

   // arithmetic right shift with floor, on 64-bit values
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint one);
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic longint atan_step(int i);
      longint t [30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
         21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
         20, 10, 5, 3, 1};
      return t[i];
   endfunction

   // sine and cosine of a binary angle, q30
   function automatic void angle_sincos(input logic [15:0] ang, output longint s,
                                        output longint c);
      logic [31:0] a;
      logic [1:0]  quad;
      bit     flip;
      longint x, y, z, nx;
      a = {ang, 16'h0};
      quad = a[31:30];
      flip = (quad == 2'd1 || quad == 2'd2);
      if (flip) a = a + 32'h8000_0000;
      z = a[31] ? longint'(a) - (64'sd1 <<< 32) : longint'(a);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y  = y + floor_shift(x, i);
            z  = z - atan_step(i);
         end else begin
            nx = x + floor_shift(y, i);
            y  = y - floor_shift(x, i);
            z  = z + atan_step(i);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clip(x, 64'sd1 <<< 30);
      s = clip(y, 64'sd1 <<< 30);
   endfunction

   function automatic logic [15:0] to_q14(longint q30);
      longint v;
      v = clip(floor_shift(q30 + (64'sd1 <<< 15), 16), 16384);
      return v[15:0];
   endfunction

   // expected packed rotation matrix for one angle beat
   function automatic logic [143:0] rotation_of(angles_type a);
      longint sy, cy, sp, cp, sr, cr, cy_sp, sy_sp;
      logic [15:0] e [9];
      angle_sincos(a.yaw, sy, cy);
      angle_sincos(a.pitch, sp, cp);
      angle_sincos(a.roll, sr, cr);
      cy_sp = mul_q30(cy, sp);
      sy_sp = mul_q30(sy, sp);
      e[0] = to_q14(mul_q30(cy, cp));
      e[1] = to_q14(mul_q30(sy, cp));
      e[2] = to_q14(-sp);
      e[3] = to_q14(mul_q30(cy_sp, sr) - mul_q30(sy, cr));
      e[4] = to_q14(mul_q30(cy, cr) + mul_q30(sy_sp, sr));
      e[5] = to_q14(mul_q30(cp, sr));
      e[6] = to_q14(mul_q30(sr, sy) + mul_q30(cy_sp, cr));
      e[7] = to_q14(mul_q30(sy_sp, cr) - mul_q30(cy, sr));
      e[8] = to_q14(mul_q30(cp, cr));
      return {e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};
   endfunction

   // directed rows: angles and, where obvious, the expected matrix
   typedef struct {
      angles_type   ang;
      bit           typed;
      logic [143:0] mat;
   } row_type;

   localparam logic [15:0] P1 = 16'sd16384;
   localparam logic [15:0] M1 = -16'sd16384;
   localparam logic [15:0] Z0 = 16'd0;

   row_type directed [] = '{
      // all zero: identity
      '{'{16'h0, 16'h0, 16'h0}, 1, {P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1}},
      // yaw a quarter turn: x forward becomes y
      '{'{16'h0, 16'h0, 16'h4000}, 1, {P1, Z0, Z0, Z0, Z0, M1, Z0, P1, Z0}},
      // yaw a half turn
      '{'{16'h0, 16'h0, 16'h8000}, 1, {P1, Z0, Z0, Z0, M1, Z0, Z0, Z0, M1}},
      '{'{16'h0, 16'h0, 16'hC000}, 0, '0},
      '{'{16'h0, 16'h4000, 16'h0}, 0, '0},
      '{'{16'h0, 16'h8000, 16'h0}, 0, '0},
      '{'{16'h0, 16'hC000, 16'h0}, 0, '0},
      '{'{16'h4000, 16'h0, 16'h0}, 0, '0},
      '{'{16'h8000, 16'h0, 16'h0}, 0, '0},
      '{'{16'hC000, 16'h0, 16'h0}, 0, '0},
      // all ones, and quadrant borders either side
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, '0},
      '{'{16'h0001, 16'h0001, 16'h0001}, 0, '0},
      '{'{16'h3FFF, 16'h4001, 16'h7FFF}, 0, '0},
      '{'{16'h8001, 16'hBFFF, 16'hC001}, 0, '0},
      '{'{16'h2000, 16'h6000, 16'hA000}, 0, '0},
      '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 0, '0},
      '{'{16'h5555, 16'hAAAA, 16'h5555}, 0, '0},
      '{'{16'h1234, 16'hEDCB, 16'h8000}, 0, '0}
   };

   // drive one angle beat and wait for its acceptance; valid drops only while idling
   task automatic send_angles(angles_type a, bit typed, logic [143:0] mat);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= a;
      matrix_queue.push_back(typed ? mat : rotation_of(a));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: stall at random, or hold off during a pressure stretch
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   // checker: compare every rsp beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (matrix_queue.size() == 0) begin
            $display("%0t unexpected rsp beat %h", $time, rsp_tdata);
            errors++;
         end else begin
            logic [143:0] want;
            want = matrix_queue.pop_front();
            for (int k = 0; k < 9; k++)
               if (rsp_tdata[16*k +: 16] !== want[16*k +: 16]) begin
                  $display("%0t entry %0d expected %0d actual %0d", $time, k,
                           $signed(want[16*k +: 16]), $signed(rsp_tdata[16*k +: 16]));
                  errors++;
               end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      angles_type a;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed table, no idling
      foreach (directed[i]) send_angles(directed[i].ang, directed[i].typed, directed[i].mat);
      // long receiver hold-off while the sender keeps offering beats
      hold_off = 1;
      fork
         begin
            repeat (120) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 60; i++) begin
            a = {16'($urandom), 16'($urandom), 16'($urandom)};
            send_angles(a, 0, '0);
         end
      join
      // random beats over idling and stalling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 57; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         for (int i = 0; i < (N_RANDOM - 60) / 4; i++) begin
            // some beats stay near quadrant borders, the rest anywhere
            if ($urandom_range(3) == 0)
               a = {16'($urandom_range(3) << 14) + 16'($urandom_range(4)) - 16'd2,
                    16'($urandom_range(3) << 14) + 16'($urandom_range(4)) - 16'd2,
                    16'($urandom_range(3) << 14) + 16'($urandom_range(4)) - 16'd2};
            else
               a = {16'($urandom), 16'($urandom), 16'($urandom)};
            send_angles(a, 0, '0);
         end
      end
      req_tvalid <= 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
